/* rtl/core/fip_pkg.sv */
// shared types, constants and hash helper functions for the feistel index permutation
// no dependencies
package fip_pkg;

    localparam int KEY_BYTES     = 16;
    localparam int MAX_HALF_BITS = 16;

    localparam int DOM_W = 31;
    localparam int RC_W  = 8;
    localparam int KL_W  = 5;
    localparam int KEY_W = 64;

    typedef enum logic [2:0] {
        CFG_DOMAIN   = 3'd0,
        CFG_ROUNDS   = 3'd1,
        CFG_KEY_LEN  = 3'd2,
        CFG_KEY_HIGH = 3'd3,
        CFG_KEY_LOW  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_ROUNDS = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_LOAD,
        S_HASH,
        S_FIN,
        S_CHECK,
        S_OUT
    } t_state;

    localparam logic [31:0] SHA_IV7 = 32'h5be0cd19;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

endpackage

/* rtl/core/feistel_index_permutation_top.sv */
// keyed feistel index permutation with cycle walking, one shared sha-256 round unit
// per request a length scan, then per pass load, hash and finish for each round, then a check
// error items and single-index domains give their result in the cycle after acceptance
// one item at a time; input stalls until its result is taken, next item accepted in the cycle after that
// the sha-256 round unit (one compression round a cycle, 64 per feistel round) sets the rate
// synchronous active-low reset: registers back to domain 2, 4 rounds, key length 16, key 0
// depends on fip_pkg
module feistel_index_permutation_top #(
    parameter int MAX_HALF_BITS = fip_pkg::MAX_HALF_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_req_type,
    input  logic [fip_pkg::DOM_W-1:0] i_index,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [fip_pkg::DOM_W-1:0] o_mapped_index,
    output logic [1:0]                o_status,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [2:0]                i_cfg_index,
    input  logic [fip_pkg::KEY_W-1:0] i_cfg_data
);
    import fip_pkg::*;

    localparam int MH = MAX_HALF_BITS;
    localparam int HW = $clog2(MH + 1);
    localparam int VW = (2 * MH > DOM_W) ? 2 * MH : DOM_W;

    // configuration
    logic [DOM_W-1:0] r_domain;
    logic [RC_W-1:0]  r_rounds;
    logic [KL_W-1:0]  r_key_len;
    logic [KEY_W-1:0] r_key_high;
    logic [KEY_W-1:0] r_key_low;

    t_state r_state, n_state;

    logic             r_inv;
    logic [DOM_W-1:0] r_idx;
    logic [DOM_W-1:0] r_v;
    logic [5:0]       r_k;
    logic [HW-1:0]    r_half;
    logic [MH-1:0]    r_l, r_r;
    logic [RC_W-1:0]  r_rnd;
    logic [RC_W-1:0]  r_cnt;
    logic [5:0]       r_j;
    logic [31:0]      r_w [16];
    logic [31:0]      r_s [8];
    logic [DOM_W-1:0] r_out_idx;
    t_status          r_out_st;

    logic [MH-1:0]    mask;
    logic [VW-1:0]    val;
    logic             val_in;
    logic [5:0]       k_min, k_even;
    logic [HW-1:0]    half_new;
    logic [VW-1:0]    idx_ext;
    logic [KL_W-1:0]  klen;
    logic [127:0]     key_all, key_mask;
    logic [511:0]     blk, tail;
    logic [8:0]       msg_bits;
    logic [63:0]      src64;
    logic [31:0]      t1, t2, w_new, fout32;
    logic [MH-1:0]    f_bits;
    logic             last_round;
    logic             accept;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_domain   <= DOM_W'(2);
            r_rounds   <= RC_W'(4);
            r_key_len  <= KL_W'(16);
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DOMAIN:   r_domain   <= i_cfg_data[DOM_W-1:0];
                CFG_ROUNDS:   r_rounds   <= i_cfg_data[RC_W-1:0];
                CFG_KEY_LEN:  r_key_len  <= i_cfg_data[KL_W-1:0];
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pass helpers
    assign mask    = {MH{1'b1}} >> (HW'(MH) - r_half);
    assign val     = (VW'(r_l) << r_half) | VW'(r_r);
    assign val_in  = val < VW'(r_domain);
    assign k_min   = (r_k < 6'd2) ? 6'd2 : r_k;
    assign k_even  = k_min + 6'(k_min[0]);
    assign half_new = ({1'b0, k_even[5:1]} > 6'(MH)) ? HW'(MH) : HW'(k_even[5:1]);
    assign idx_ext = VW'(r_idx);

    // message block: key bytes, round be32, half be64, pad byte, length
    assign klen     = (32'(r_key_len) > KEY_BYTES) ? KL_W'(KEY_BYTES) : r_key_len;
    assign key_all  = {r_key_high, r_key_low};
    assign key_mask = (klen >= KL_W'(16)) ? {128{1'b1}} : ~({128{1'b1}} >> {klen, 3'b000});
    assign src64    = r_inv ? 64'(r_l) : 64'(r_r);
    assign tail     = {24'd0, r_rnd, src64, 8'h80, 408'd0} >> {klen, 3'b000};
    assign msg_bits = {klen + KL_W'(12), 3'b000};
    assign blk      = {key_all & key_mask, 384'd0} | tail | 512'(msg_bits);

    // one compression round
    assign t1 = r_s[7] + bsig1(r_s[4]) + ((r_s[4] & r_s[5]) ^ (~r_s[4] & r_s[6]))
              + SHA_K[r_j] + r_w[0];
    assign t2 = bsig0(r_s[0]) + ((r_s[0] & r_s[1]) ^ (r_s[0] & r_s[2]) ^ (r_s[1] & r_s[2]));
    assign w_new = r_w[0] + ssig0(r_w[1]) + r_w[9] + ssig1(r_w[14]);

    assign fout32     = SHA_IV7 + r_s[7];
    assign f_bits     = fout32[MH-1:0];
    assign last_round = ({1'b0, r_cnt} + 9'd1) == {1'b0, r_rounds};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_index >= r_domain || r_domain <= DOM_W'(1) || r_rounds == '0) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_LEN;
                    end
                end
            end
            S_LEN: begin
                if (r_v == '0) n_state = S_LOAD;
            end
            S_LOAD: n_state = S_HASH;
            S_HASH: begin
                if (r_j == 6'd63) n_state = S_FIN;
            end
            S_FIN: n_state = last_round ? S_CHECK : S_LOAD;
            S_CHECK: n_state = val_in ? S_OUT : S_LOAD;
            S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_inv <= i_req_type;
                    r_idx <= i_index;
                    r_v   <= r_domain - DOM_W'(1);
                    r_k   <= '0;
                    r_out_idx <= '0;
                    if (i_index >= r_domain) r_out_st <= ST_RANGE;
                    else if (r_domain > DOM_W'(1) && r_rounds == '0) r_out_st <= ST_ROUNDS;
                    else r_out_st <= ST_OK;
                end
            end
            S_LEN: begin
                if (r_v != '0) begin
                    r_k <= r_k + 6'd1;
                    r_v <= r_v >> 1;
                end else begin
                    r_half <= half_new;
                    r_l    <= MH'(idx_ext >> half_new) & ({MH{1'b1}} >> (HW'(MH) - half_new));
                    r_r    <= idx_ext[MH-1:0] & ({MH{1'b1}} >> (HW'(MH) - half_new));
                    r_cnt  <= '0;
                    r_rnd  <= r_inv ? r_rounds - RC_W'(1) : '0;
                end
            end
            S_LOAD: begin
                for (int i = 0; i < 16; i++) begin
                    r_w[i] <= blk[511 - 32 * i -: 32];
                end
                for (int i = 0; i < 8; i++) begin
                    r_s[i] <= SHA_IV[i];
                end
                r_j <= '0;
            end
            S_HASH: begin
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i + 1];
                end
                r_w[15] <= w_new;
                r_s[0] <= t1 + t2;
                r_s[1] <= r_s[0];
                r_s[2] <= r_s[1];
                r_s[3] <= r_s[2];
                r_s[4] <= r_s[3] + t1;
                r_s[5] <= r_s[4];
                r_s[6] <= r_s[5];
                r_s[7] <= r_s[6];
                r_j    <= r_j + 6'd1;
            end
            S_FIN: begin
                if (!r_inv) begin
                    r_l <= r_r;
                    r_r <= (r_l ^ f_bits) & mask;
                    r_rnd <= r_rnd + RC_W'(1);
                end else begin
                    r_r <= r_l;
                    r_l <= (r_r ^ f_bits) & mask;
                    r_rnd <= r_rnd - RC_W'(1);
                end
                r_cnt <= r_cnt + RC_W'(1);
            end
            S_CHECK: begin
                // store the current value; out of domain: walk again from it
                r_cnt <= '0;
                r_rnd <= r_inv ? r_rounds - RC_W'(1) : '0;
                r_out_idx <= val[DOM_W-1:0];
            end
            default: ;
        endcase
    end

    assign o_mapped_index = r_out_idx;
    assign o_status       = r_out_st;

    a_hash_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HASH && r_j != 6'd63) |=> (r_state == S_HASH && r_j == $past(r_j) + 6'd1))
        else $error("hash round counter slipped");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("input taken while a result waits");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_mapped_index == '0))
        else $error("error result carries an index");

    a_ok_in_domain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OK && r_domain > DOM_W'(1)) |-> (o_mapped_index < r_domain))
        else $error("result outside domain");

    a_round_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_cnt < r_rounds))
        else $error("feistel round count overran");

endmodule
